// ===== rtl/lru_kv_pkg.sv =====
// lru_kv_pkg: shared widths, opcodes and the command and status structs
// between the controller and the datapath of the lru key/value store.
// No dependencies.
`default_nettype none

package lru_kv_pkg;

   // field widths fixed by the interface
   localparam int KEY_WIDTH       = 32;
   localparam int VALUE_WIDTH     = 32;
   localparam int CAP_WIDTH       = 5;

   // default build size and capacity after reset
   localparam int ENTRIES_DEFAULT = 16;
   localparam int CAP_RESET       = 16;

   // operation codes carried on req_opcode
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // capture the incoming word
      logic move;       // move the matching entry to the most recent slot
      logic evict;      // drop the least recent entry
      logic append;     // write the new entry after the live ones
      logic load_rsp;   // capture the lookup outcome for the response
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_put;     // held word is a put
      logic hit;        // held key is among the live entries
      logic full;       // live count has reached capacity
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/lru_kv_dpath.sv =====
// lru_kv_dpath: entry chain in recency order, parallel key compare,
// capacity and live count registers, response register.
// Depends on lru_kv_pkg.
`default_nettype none

module lru_kv_dpath #(
   parameter int ENTRIES = lru_kv_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [lru_kv_pkg::CAP_WIDTH-1:0]      csr_write_data,
   input  wire logic                                  req_opcode,
   input  wire logic [lru_kv_pkg::KEY_WIDTH-1:0]      req_key,
   input  wire logic [lru_kv_pkg::VALUE_WIDTH-1:0]    req_write_value,
   input  wire lru_kv_pkg::cmd_type                   cmd,
   output lru_kv_pkg::sts_type                        sts,
   output logic                                       rsp_found,
   output logic [lru_kv_pkg::VALUE_WIDTH-1:0]         rsp_read_value
);

   localparam int CW      = $clog2(ENTRIES + 1);
   localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CAP_RST = (lru_kv_pkg::CAP_RESET > ENTRIES) ? ENTRIES
                                                               : lru_kv_pkg::CAP_RESET;

   // held request word
   logic                                   op_put_ff;
   logic [lru_kv_pkg::KEY_WIDTH-1:0]       op_key_ff;
   logic [lru_kv_pkg::VALUE_WIDTH-1:0]     op_value_ff;

   // capacity (stored already clamped) and live count
   logic [CW-1:0]                          cap_ff, cap_in;
   logic [CW-1:0]                          count_ff, count_in;
   logic [31:0]                            wr_wide;

   // entry chain, slot 0 least recent
   logic [lru_kv_pkg::KEY_WIDTH-1:0]       cell_key_ff   [ENTRIES];
   logic [lru_kv_pkg::VALUE_WIDTH-1:0]     cell_value_ff [ENTRIES];

   // lookup
   logic [ENTRIES-1:0]                     match;
   logic [IW-1:0]                          slot_idx;
   logic [lru_kv_pkg::VALUE_WIDTH-1:0]     hit_value;
   logic [lru_kv_pkg::VALUE_WIDTH-1:0]     new_value;

   // response register
   logic                                   rsp_found_ff;
   logic [lru_kv_pkg::VALUE_WIDTH-1:0]     rsp_value_ff;

   // capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_put_ff   <= (req_opcode == lru_kv_pkg::OP_PUT);
         op_key_ff   <= req_key;
         op_value_ff <= req_write_value;
      end
   end

   // capacity clamp to 1..ENTRIES on write
   assign wr_wide = 32'(csr_write_data);

   always_comb begin
      cap_in = cap_ff;
      if (csr_write_enable) begin
         priority if (wr_wide == 32'd0) begin
            cap_in = CW'(1);
         end else if (wr_wide > 32'(ENTRIES)) begin
            cap_in = CW'(ENTRIES);
         end else begin
            cap_in = CW'(csr_write_data);
         end
      end
   end

   // live count
   always_comb begin
      count_in = count_ff;
      priority if (cmd.evict) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CW'(CAP_RST);
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         count_ff <= count_in;
      end
   end

   // parallel compare over the live entries; keys are unique, so the
   // one-hot match folds straight into slot and value
   always_comb begin
      match     = '0;
      slot_idx  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (i < int'(count_ff)) && (cell_key_ff[i] == op_key_ff);
         if (match[i]) begin
            slot_idx  = slot_idx | IW'(i);
            hit_value = hit_value | cell_value_ff[i];
         end
      end
   end

   assign new_value = op_put_ff ? op_value_ff : hit_value;

   // per-slot update: shift down towards slot 0 or take the new entry
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      localparam int NXT = (i + 1 < ENTRIES) ? i + 1 : i;
      logic shift_dn;
      logic load_new;

      assign shift_dn = (cmd.move  && (i >= int'(slot_idx)) && (i + 1 < int'(count_ff)))
                     || (cmd.evict && (i + 1 < int'(count_ff)));
      assign load_new = (cmd.move   && (i + 1 == int'(count_ff)))
                     || (cmd.append && (i == int'(count_ff)));

      always_ff @(posedge clock) begin
         if (load_new) begin
            cell_key_ff[i]   <= op_key_ff;
            cell_value_ff[i] <= new_value;
         end else if (shift_dn) begin
            cell_key_ff[i]   <= cell_key_ff[NXT];
            cell_value_ff[i] <= cell_value_ff[NXT];
         end
      end
   end

   // response word, value is zero on a miss
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_found_ff <= |match;
         rsp_value_ff <= hit_value;
      end
   end

   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   // status to the controller
   assign sts.is_put = op_put_ff;
   assign sts.hit    = |match;
   assign sts.full   = (count_ff >= cap_ff);

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(ENTRIES))
      else $error("live count beyond entry count");

   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      (cap_ff != '0) && (32'(cap_ff) <= 32'(ENTRIES)))
      else $error("capacity outside its clamp");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (count_ff < cap_ff) && !(|match))
      else $error("append without room or with key present");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not grow the live count");

   a_move_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.move |-> (|match) && (count_ff != '0))
      else $error("move issued without a matching entry");

endmodule

`default_nettype wire

// ===== rtl/lru_kv_ctrl.sv =====
// lru_kv_ctrl: state machine that sequences accept, lookup/update and
// eviction, and owns the response valid flag.
// Depends on lru_kv_pkg.
`default_nettype none

module lru_kv_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire lru_kv_pkg::sts_type   sts,
   output lru_kv_pkg::cmd_type        cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // response slot can take a new word this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (!sts.is_put) begin
               // get: waits only for the response slot
               if (rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  cmd.move     = sts.hit;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (sts.hit) begin
               cmd.move = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.full) begin
               // drop the least recent entry and look again
               cmd.evict = 1'b1;
            end else begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/lru_cache_key_value_top.sv =====
// lru_cache_key_value_top: fully associative key/value store with least
// recently used replacement. Instantiates lru_kv_ctrl and lru_kv_dpath;
// depends on lru_kv_pkg.
//
// A word is captured while idle and worked in the execute state, where
// every live entry's key is compared at once and the recency chain shifts
// by one slot. A put of an absent key into a full store first evicts the
// least recent entry, once per pass, until there is room (one entry, or
// more after capacity has been lowered below the live count). A get also
// waits in the execute state while the previous response has not been
// taken; a new word may be accepted while a response waits. Capacity
// writes are clamped to 1..ENTRIES and are meant for idle periods only.
`default_nettype none

module lru_cache_key_value_top #(
   parameter int ENTRIES = lru_kv_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_write_enable,
   input  wire logic [lru_kv_pkg::CAP_WIDTH-1:0]      csr_write_data,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_opcode,
   input  wire logic [lru_kv_pkg::KEY_WIDTH-1:0]      req_key,
   input  wire logic [lru_kv_pkg::VALUE_WIDTH-1:0]    req_write_value,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_found,
   output logic [lru_kv_pkg::VALUE_WIDTH-1:0]         rsp_read_value
);

   lru_kv_pkg::cmd_type cmd;
   lru_kv_pkg::sts_type sts;

   // sequencing
   lru_kv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, compare and response word
   lru_kv_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .req_write_value  (req_write_value),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_found        (rsp_found),
      .rsp_read_value   (rsp_read_value)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_lru_cache_key_value_top.sv =====
// tb_lru_cache_key_value_top: self-checking bench for the lru key/value store,
// with a clocked driver and monitor, its own recency-ordered model and checks.
// Depends on lru_kv_pkg and lru_cache_key_value_top.
module tb_lru_cache_key_value_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES       = lru_kv_pkg::ENTRIES_DEFAULT;
   localparam int KEY_W         = lru_kv_pkg::KEY_WIDTH;
   localparam int VALUE_W       = lru_kv_pkg::VALUE_WIDTH;
   localparam int CAP_W         = lru_kv_pkg::CAP_WIDTH;
   localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
   localparam int HOLD_CYCLES   = 300;

   typedef struct {
      logic               opcode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } kv_request_type;

   typedef struct {
      logic               found;
      logic [VALUE_W-1:0] value;
   } lookup_result_type;

   // clock, reset and block ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [CAP_W-1:0]   csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = lru_kv_pkg::OP_GET;
   logic [KEY_W-1:0]   req_key = '0;
   logic [VALUE_W-1:0] req_write_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_found;
   logic [VALUE_W-1:0] rsp_read_value;

   // stimulus and checking state
   kv_request_type    pending_requests[$];
   lookup_result_type expected_lookups[$];
   kv_request_type    next_request;
   lookup_result_type lookup_due;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   logic              rsp_hold = 1'b0;
   int                mismatches = 0;

   // model of the store: slot 0 least recent
   logic [KEY_W-1:0]   model_keys[ENTRIES];
   logic [VALUE_W-1:0] model_values[ENTRIES];
   int                 model_live = 0;
   logic [CAP_W-1:0]   model_capacity = CAP_W'(lru_kv_pkg::CAP_RESET);

   lru_cache_key_value_top #(.ENTRIES(ENTRIES)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_read_value   (rsp_read_value)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // capacity as the store uses it: zero means one, above the build size means all
   function automatic int clamp_capacity(input logic [CAP_W-1:0] cap);
      if (cap == 0) return 1;
      if (cap > ENTRIES) return ENTRIES;
      return int'(cap);
   endfunction

   // remove a slot and close the gap towards the least recent end
   task automatic drop_slot(input int slot);
      int j;
      for (j = slot; j + 1 < model_live; j++) begin
         model_keys[j]   = model_keys[j + 1];
         model_values[j] = model_values[j + 1];
      end
      model_live--;
   endtask

   task automatic add_most_recent(input logic [KEY_W-1:0] key,
                                  input logic [VALUE_W-1:0] value);
      if (model_live < ENTRIES) begin
         model_keys[model_live]   = key;
         model_values[model_live] = value;
         model_live++;
      end
   endtask

   // append one lookup outcome to the expected queue
   task automatic queue_lookup(input logic found, input logic [VALUE_W-1:0] value);
      lookup_result_type entry;
      entry.found = found;
      entry.value = value;
      expected_lookups.insert(expected_lookups.size(), entry);
   endtask

   // one accepted word: update recency order, queue the lookup outcome of a get
   task automatic lru_access(input logic opcode, input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] value);
      int                 slot;
      int                 i;
      int                 cap;
      logic [VALUE_W-1:0] hit_value;
      slot = model_live;
      for (i = model_live - 1; i >= 0; i--)
         if (model_keys[i] == key) slot = i;
      if (opcode == lru_kv_pkg::OP_GET) begin
         if (slot < model_live) begin
            hit_value = model_values[slot];
            drop_slot(slot);
            add_most_recent(key, hit_value);
            queue_lookup(1'b1, hit_value);
         end else begin
            queue_lookup(1'b0, '0);
         end
      end else begin
         if (slot < model_live) begin
            drop_slot(slot);
         end else begin
            cap = clamp_capacity(model_capacity);
            while (model_live >= cap && model_live > 0) drop_slot(0);
         end
         add_most_recent(key, value);
      end
   endtask

   // driver: holds each word until taken, then offers the next or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            lru_access(req_opcode, req_key, req_write_value);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_request = pending_requests.pop_front();
               req_valid       <= 1'b1;
               req_opcode      <= next_request.opcode;
               req_key         <= next_request.key;
               req_write_value <= next_request.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each response word against the oldest outstanding lookup
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               mismatches++;
               $display("%0t: response with no lookup outstanding, expected none, %s",
                        $time, "got:");
               $display("%0t:    found=%0b value=%h", $time, rsp_found, rsp_read_value);
            end else begin
               lookup_due = expected_lookups.pop_front();
               if (rsp_found !== lookup_due.found) begin
                  mismatches++;
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, lookup_due.found, rsp_found);
               end
               if (rsp_read_value !== lookup_due.value) begin
                  mismatches++;
                  $display("%0t: read_value mismatch, expected %h, got %h",
                           $time, lookup_due.value, rsp_read_value);
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic offer_word(input logic opcode, input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] value);
      kv_request_type item;
      item.opcode = opcode;
      item.key    = key;
      item.value  = value;
      pending_requests.insert(pending_requests.size(), item);
   endtask

   // wait until every word is taken and answered, then let evictions finish
   task automatic drain();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_lookups.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      drain();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_capacity = cap;
   endtask

   // random traffic over a small key set so that hits and evictions are common
   task automatic random_phase(input logic [CAP_W-1:0] cap, input int send_pct,
                               input int recv_pct, input int n_words, input bit hold_rsp);
      logic [KEY_W-1:0] key_pool[$];
      logic [KEY_W-1:0] key;
      logic             opcode;
      int               i;
      set_capacity(cap);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (i = 0; i < clamp_capacity(cap) + 3; i++)
         key_pool.insert(key_pool.size(),
                         i == 0 ? KEY_W'(0) : i == 1 ? '1 : KEY_W'($urandom()));
      rsp_hold = hold_rsp;
      for (i = 0; i < n_words; i++) begin
         opcode = ($urandom_range(1) == 1) ? lru_kv_pkg::OP_PUT : lru_kv_pkg::OP_GET;
         if ($urandom_range(99) < 85)
            key = key_pool[$urandom_range(key_pool.size() - 1)];
         else
            key = $urandom();
         offer_word(opcode, key, $urandom());
      end
      // long receiver hold-off while the sender keeps offering
      if (hold_rsp) begin
         repeat (HOLD_CYCLES) @(negedge clock);
         rsp_hold = 1'b0;
      end
      drain();
   endtask

   // reset, directed words, then random phases over several capacities
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty store, extreme keys and values, update of a present key
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
      offer_word(lru_kv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_word(lru_kv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_word(lru_kv_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);

      // two entries: eviction of the least recent, miss on the evicted key
      set_capacity(5'd2);
      @(negedge clock);
      offer_word(lru_kv_pkg::OP_PUT, 32'h0000_0001, 32'h0000_0011);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_PUT, 32'h0000_0002, 32'h0000_0022);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0002, 32'h0000_0000);

      // capacity lowered below the live count: gets still see all, a put trims
      set_capacity(5'd1);
      @(negedge clock);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_PUT, 32'h0000_0003, 32'h8000_0001);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0002, 32'h0000_0000);
      offer_word(lru_kv_pkg::OP_GET, 32'h0000_0003, 32'h0000_0000);

      random_phase(5'd16,  0,  0, 120, 1'b1);
      random_phase(5'd4,  67,  0, 110, 1'b0);
      random_phase(5'd1,   0, 67, 110, 1'b0);
      random_phase(5'd31, 34, 34, 110, 1'b0);
      random_phase(5'd0,   0,  0, 110, 1'b0);
      random_phase(5'd17, 67,  0, 110, 1'b0);
      random_phase(5'd8,   0, 67, 110, 1'b0);
      random_phase(5'd3,  34, 34, 110, 1'b0);
      drain();

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // overall time limit
   initial begin
      #(2_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
